// File: rtl/atok_pkg.sv
// ----------------------------------------------------------------------------
// atok_pkg: shared types and constants of the assembly tokenizer
// Token kinds, lexer modes, character codes, result record and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package atok_pkg;

  localparam int POSITION_BITS = 16;
  localparam int FIELD_POS_W   = 16;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [FIELD_POS_W-1:0]   field_t;

  localparam pos_t POS_MAX = '1;
  localparam pos_t POS_ONE = pos_t'(1);

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_NUMBER = 2'd1;
  localparam logic [1:0] MODE_LABEL  = 2'd2;
  localparam logic [1:0] MODE_INSTR  = 2'd3;

  localparam logic [2:0] TK_NUMBER = 3'd0;
  localparam logic [2:0] TK_LABEL  = 3'd1;
  localparam logic [2:0] TK_INSTR  = 3'd2;
  localparam logic [2:0] TK_END    = 3'd3;
  localparam logic [2:0] TK_TEXT   = 3'd4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [7:0]  text_byte;
    logic [31:0] number_value;
    field_t      start_column;
    field_t      line_number;
    field_t      text_length;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_out_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] accumulator;
    pos_t        current_line;
    pos_t        current_column;
    pos_t        token_start;
    pos_t        byte_count;
  } lex_state_t;

  localparam lex_state_t LEX_RESET = '{
    mode:           MODE_IDLE,
    accumulator:    32'd0,
    current_line:   POS_ONE,
    current_column: POS_ONE,
    token_start:    POS_ONE,
    byte_count:     '0
  };

  function automatic pos_t sat_inc(input pos_t v);
    return (v == POS_MAX) ? v : v + POS_ONE;
  endfunction

  function automatic field_t pos_field(input pos_t v);
    return field_t'(v);
  endfunction

endpackage

`default_nettype wire

// File: rtl/atok_lexer.sv
// ----------------------------------------------------------------------------
// atok_lexer: lexer state and per-item token logic
// Holds mode, accumulator and position counters; turns one item into up to
// two result records in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module atok_lexer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_kind,
  input  wire logic [7:0]          in_ch,
  output atok_pkg::step_out_t      step
);

  atok_pkg::lex_state_t st;
  atok_pkg::lex_state_t st_next;
  atok_pkg::result_t    flush_r;
  atok_pkg::result_t    sec_r;
  logic                 flush_v;
  logic                 sec_v;
  logic                 take_idle;
  logic                 is_digit;
  logic                 is_term;
  logic [3:0]           digit;

  assign is_digit = (in_ch >= atok_pkg::CH_ZERO) && (in_ch <= atok_pkg::CH_NINE);
  assign is_term  = (in_ch == atok_pkg::CH_SPACE) || (in_ch == atok_pkg::CH_NL) ||
                    (in_ch == atok_pkg::CH_TAB) || (in_ch == atok_pkg::CH_DOT);
  assign digit    = 4'(in_ch - atok_pkg::CH_ZERO);

  // pending token record, used when a token closes
  always_comb begin
    flush_r              = '0;
    flush_r.start_column = atok_pkg::pos_field(st.token_start);
    flush_r.line_number  = atok_pkg::pos_field(st.current_line);
    if (st.mode == atok_pkg::MODE_NUMBER) begin
      flush_r.token_kind   = atok_pkg::TK_NUMBER;
      flush_r.number_value = st.accumulator;
    end else begin
      flush_r.token_kind  = (st.mode == atok_pkg::MODE_LABEL) ? atok_pkg::TK_LABEL
                                                              : atok_pkg::TK_INSTR;
      flush_r.text_length = atok_pkg::pos_field(st.byte_count);
    end
    flush_r.last = !sec_v;
  end

  always_comb begin
    st_next   = st;
    flush_v   = 1'b0;
    sec_v     = 1'b0;
    sec_r     = '0;
    take_idle = 1'b1;
    if (in_kind) begin
      take_idle          = 1'b0;
      flush_v            = (st.mode != atok_pkg::MODE_IDLE);
      sec_v              = 1'b1;
      sec_r.token_kind   = atok_pkg::TK_END;
      sec_r.start_column = atok_pkg::pos_field(st.current_column);
      sec_r.line_number  = atok_pkg::pos_field(st.current_line);
      st_next            = atok_pkg::LEX_RESET;
    end else begin
      unique case (st.mode)
        atok_pkg::MODE_IDLE: begin
        end
        atok_pkg::MODE_NUMBER: begin
          if (is_digit) begin
            take_idle              = 1'b0;
            st_next.accumulator    = (st.accumulator << 3) + (st.accumulator << 1)
                                     + 32'(digit);
            st_next.current_column = atok_pkg::sat_inc(st.current_column);
          end else begin
            flush_v = 1'b1;
          end
        end
        atok_pkg::MODE_LABEL, atok_pkg::MODE_INSTR: begin
          if (!is_term) begin
            take_idle              = 1'b0;
            sec_v                  = 1'b1;
            st_next.byte_count     = atok_pkg::sat_inc(st.byte_count);
            sec_r.token_kind       = atok_pkg::TK_TEXT;
            sec_r.text_byte        = in_ch;
            sec_r.start_column     = atok_pkg::pos_field(st.token_start);
            sec_r.line_number      = atok_pkg::pos_field(st.current_line);
            sec_r.text_length      = atok_pkg::pos_field(st_next.byte_count);
            st_next.current_column = atok_pkg::sat_inc(st.current_column);
          end else begin
            flush_v = 1'b1;
          end
        end
      endcase

      if (flush_v) begin
        st_next.mode        = atok_pkg::MODE_IDLE;
        st_next.accumulator = 32'd0;
        st_next.byte_count  = '0;
      end

      if (take_idle) begin
        if (in_ch == atok_pkg::CH_SPACE || in_ch == atok_pkg::CH_TAB) begin
          st_next.current_column = atok_pkg::sat_inc(st.current_column);
        end else if (in_ch == atok_pkg::CH_NL) begin
          st_next.current_line   = atok_pkg::sat_inc(st.current_line);
          st_next.current_column = atok_pkg::POS_ONE;
        end else if (is_digit) begin
          st_next.mode           = atok_pkg::MODE_NUMBER;
          st_next.accumulator    = 32'(digit);
          st_next.token_start    = st.current_column;
          st_next.current_column = atok_pkg::sat_inc(st.current_column);
        end else if (in_ch == atok_pkg::CH_DOT) begin
          st_next.mode           = atok_pkg::MODE_LABEL;
          st_next.byte_count     = '0;
          st_next.token_start    = st.current_column;
          st_next.current_column = atok_pkg::sat_inc(st.current_column);
        end else begin
          st_next.mode           = atok_pkg::MODE_INSTR;
          st_next.token_start    = st.current_column;
          st_next.byte_count     = atok_pkg::POS_ONE;
          st_next.current_column = atok_pkg::sat_inc(st.current_column);
          sec_v                  = 1'b1;
          sec_r.token_kind       = atok_pkg::TK_TEXT;
          sec_r.text_byte        = in_ch;
          sec_r.start_column     = atok_pkg::pos_field(st.current_column);
          sec_r.line_number      = atok_pkg::pos_field(st.current_line);
          sec_r.text_length      = atok_pkg::pos_field(atok_pkg::POS_ONE);
        end
      end
    end
    sec_r.last = 1'b1;
  end

  always_comb begin
    step.count  = in_valid ? ({1'b0, flush_v} + {1'b0, sec_v}) : 2'd0;
    step.first  = flush_v ? flush_r : sec_r;
    step.second = sec_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= atok_pkg::LEX_RESET;
    end else if (in_valid) begin
      st <= st_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/atok_queue.sv
// ----------------------------------------------------------------------------
// atok_queue: result queue between lexer and output channel
// Takes up to two records per cycle, hands out one per cycle when rd_en is set.
// ----------------------------------------------------------------------------
`default_nettype none

module atok_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  atok_pkg::step_out_t      wr,
  input  wire logic                rd_en,
  output atok_pkg::result_t        head,
  output logic                     not_empty,
  output logic                     room_two
);

  atok_pkg::result_t                 entries [atok_pkg::QUEUE_DEPTH];
  logic [atok_pkg::QUEUE_AW-1:0]     wp;
  logic [atok_pkg::QUEUE_AW-1:0]     rp;
  logic [atok_pkg::QUEUE_CW-1:0]     count;
  logic [atok_pkg::QUEUE_CW-1:0]     count_next;
  logic [atok_pkg::QUEUE_AW-1:0]     wp_second;

  assign wp_second  = wp + atok_pkg::QUEUE_AW'(1);
  assign count_next = count + atok_pkg::QUEUE_CW'(wr.count)
                      - atok_pkg::QUEUE_CW'(rd_en);
  assign head       = entries[rp];
  assign not_empty  = (count != '0);
  assign room_two   = (count <= atok_pkg::QUEUE_CW'(atok_pkg::QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (wr.count != 2'd0) begin
      entries[wp] <= wr.first;
    end
    if (wr.count == 2'd2) begin
      entries[wp_second] <= wr.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + atok_pkg::QUEUE_AW'(wr.count);
      rp    <= rp + atok_pkg::QUEUE_AW'(rd_en);
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/assembly_tokenizer.sv
// ----------------------------------------------------------------------------
// assembly_tokenizer: streaming lexer for a small assembly language
// Source bytes in, token records and streamed label/instruction bytes out.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one item per source byte: tdata[7:0] is the byte, tuser[0]
//   set marks end of source (byte ignored). m_axis carries result items:
//   tuser is the token kind, tdata the record, tlast the final result of the
//   input item that caused it.
//   with the queue empty, the first result of an item shows on m_axis in
//   the cycle after the item is taken.
//   one item per cycle while the queue has room for two results; an item
//   with two results (token flush plus text byte or end token) goes out
//   on m_axis one result at a time, so a long run of such items is paced by m_axis.
//   the lexer writes into a four-entry result queue; s_axis_tready is high
//   while the queue has room for two results, so a stalled receiver fills
//   the queue and then holds off the sender without losing anything.
//   reset clears the lexer to idle, line 1, column 1 and empties the queue;
//   an end of source item does the same to the lexer after its results.
// ----------------------------------------------------------------------------
`default_nettype none

module assembly_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // ch
  input  wire logic        s_axis_tuser,   // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [87:0]      m_axis_tdata,   // text_byte, number_value, start_column,
                                           // line_number, text_length
  output logic [2:0]       m_axis_tuser,   // token_kind
  output logic             m_axis_tlast    // last
);

  atok_pkg::step_out_t step;
  atok_pkg::result_t   head;
  logic                in_acc;
  logic                rd_en;
  logic                not_empty;
  logic                room_two;

  assign s_axis_tready = room_two;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = not_empty;
  assign rd_en         = m_axis_tvalid && m_axis_tready;

  atok_lexer u_lexer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_acc),
    .in_kind  (s_axis_tuser),
    .in_ch    (s_axis_tdata),
    .step     (step)
  );

  atok_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (step),
    .rd_en     (rd_en),
    .head      (head),
    .not_empty (not_empty),
    .room_two  (room_two)
  );

  assign m_axis_tdata = {head.text_length, head.line_number, head.start_column,
                         head.number_value, head.text_byte};
  assign m_axis_tuser = head.token_kind;
  assign m_axis_tlast = head.last;

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_axis_tuser |-> step.count != 2'd0)
    else $error("end of source produced no result");

  a_result_shows: assert property (@(posedge clk) disable iff (rst)
    in_acc && step.count != 2'd0 |=> m_axis_tvalid)
    else $error("result written but output not valid");

  a_stall_has_data: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input held off with empty queue");

  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    in_acc && step.count == 2'd2 |-> step.second.last && !step.first.last)
    else $error("last flag misplaced on result pair");

endmodule

`default_nettype wire
